FILE: src/assert_macros.svh
// Assertion macros shared by the buffer cache RTL.
// Every module that uses them has clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bbc assertion failed");

// Check that a condition implies another in the next cycle.
`define BBC_ASSERT_NEXT(lbl, cond, nxt) \
  `BBC_ASSERT(lbl, (cond) |=> (nxt))

`endif

FILE: src/bbc_pkg.sv
// Types and constants for the block buffer cache.
// Used by the controller, the datapath and the top level.
package bbc_pkg;

  localparam int NumBuffersDef = 32;
  localparam int BlockBitsDef  = 24;
  localparam int CountBitsDef  = 8;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_DIRTY   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_UNHELD  = 2'd2,
    ST_SAT     = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [23:0] block_number;
    logic [4:0]  buffer_index;
  } req_t;

  typedef struct packed {
    logic [4:0]  buffer_slot;
    logic        hit;
    logic        need_read;
    logic        write_back;
    logic [23:0] evicted_block;
    logic [5:0]  held_count;
    status_e     status;
  } rsp_t;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic locate;
    logic update;
  } ctrl_t;

endpackage

FILE: src/block_buffer_cache_lru.sv
// Top level of the block buffer cache tag manager.
// Depends on bbc_pkg, bbc_ctrl and bbc_datapath.
//
//  channel   handshake          payload   direction
//  request   start_i / busy_o   req_i     in
//  result    done_o             rsp_o     out
//
// Each request passes through accept, tag compare, free-list locate and
// state update; the result shows for one cycle on done_o as the next
// request may be accepted. busy_o is high during compare, locate and update.
// Reset puts all buffers invalid, unheld and on the free list in index
// order. The result receiver cannot stall.
module block_buffer_cache_lru #(
  parameter int NUM_BUFFERS = bbc_pkg::NumBuffersDef,
  parameter int BLOCK_BITS  = bbc_pkg::BlockBitsDef,
  parameter int COUNT_BITS  = bbc_pkg::CountBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bbc_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output bbc_pkg::rsp_t rsp_o
);

  bbc_pkg::ctrl_t ctrl;

  bbc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .ctrl_o  (ctrl)
  );

  bbc_datapath #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .BLOCK_BITS  (BLOCK_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

FILE: src/bbc_ctrl.sv
// Sequencer for the block buffer cache: capture, lookup, locate, update.
// Depends on bbc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bbc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output logic           done_o,
  output bbc_pkg::ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_LOCATE = 4'b0100,
    S_UPDATE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start_i) state_d = S_LOOKUP;
      S_LOOKUP: state_d = S_LOCATE;
      S_LOCATE: state_d = S_UPDATE;
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_UPDATE);
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign ctrl_o.capture = (state_q == S_IDLE) && start_i;
  assign ctrl_o.lookup  = (state_q == S_LOOKUP);
  assign ctrl_o.locate  = (state_q == S_LOCATE);
  assign ctrl_o.update  = (state_q == S_UPDATE);

  `BBC_ASSERT(a_done_after_accept, (start_i && !busy_o) |-> ##4 done_o)
  `BBC_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `BBC_ASSERT(a_done_idle, done_o |-> !busy_o)

endmodule

FILE: src/bbc_datapath.sv
// Tag store, reference counts, dirty bits and free list of the buffer cache.
// Depends on bbc_pkg and assert_macros.svh; stepped by bbc_ctrl.
`include "assert_macros.svh"

module bbc_datapath #(
  parameter int NUM_BUFFERS = bbc_pkg::NumBuffersDef,
  parameter int BLOCK_BITS  = bbc_pkg::BlockBitsDef,
  parameter int COUNT_BITS  = bbc_pkg::CountBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bbc_pkg::ctrl_t ctrl_i,
  input  bbc_pkg::req_t  req_i,
  output bbc_pkg::rsp_t  rsp_o
);

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam int HW = $clog2(NUM_BUFFERS + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [HW-1:0] NumB = HW'(NUM_BUFFERS);

  logic [BLOCK_BITS-1:0] tag_q [NUM_BUFFERS];
  logic [BLOCK_BITS-1:0] tag_d [NUM_BUFFERS];
  logic [COUNT_BITS-1:0] cnt_q [NUM_BUFFERS];
  logic [COUNT_BITS-1:0] cnt_d [NUM_BUFFERS];
  logic [IW-1:0]         lru_q [NUM_BUFFERS];
  logic [IW-1:0]         lru_d [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] valid_q, valid_d, dirty_q, dirty_d;
  logic [HW-1:0]         len_q, len_d, held_q, held_d;

  bbc_pkg::req_t         req_q;
  bbc_pkg::rsp_t         rsp_q, rsp_d;
  logic                  found_q, found_d, in_list_q, in_list_d;
  logic [IW-1:0]         slot_q, slot_d, pos_q, pos_d;

  logic [31:0]           blk_ext, idx_ext;
  logic [BLOCK_BITS-1:0] blk;
  logic [IW-1:0]         idx;
  logic                  idx_ok;

  assign blk_ext = 32'(req_q.block_number);
  assign blk     = blk_ext[BLOCK_BITS-1:0];
  assign idx_ext = 32'(req_q.buffer_index);
  assign idx     = idx_ext[IW-1:0];
  assign idx_ok  = (idx_ext < 32'(NUM_BUFFERS));

  // Associative tag compare, lowest index wins.
  always_comb begin
    found_d = 1'b0;
    slot_d  = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (valid_q[i] && (tag_q[i] == blk)) begin
        found_d = 1'b1;
        slot_d  = IW'(i);
      end
    end
  end

  // Position of the hit buffer within the free list.
  always_comb begin
    in_list_d = 1'b0;
    pos_d     = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if ((HW'(i) < len_q) && (lru_q[i] == slot_q)) begin
        in_list_d = 1'b1;
        pos_d     = IW'(i);
      end
    end
  end

  always_comb begin
    logic          rm;
    logic          app;
    logic [IW-1:0] rpos;
    logic [IW-1:0] s;
    logic [31:0]   slot_ext;
    logic [31:0]   ev_ext;
    logic [31:0]   held_ext;

    tag_d   = tag_q;
    cnt_d   = cnt_q;
    lru_d   = lru_q;
    valid_d = valid_q;
    dirty_d = dirty_q;
    len_d   = len_q;
    held_d  = held_q;
    rm      = 1'b0;
    app     = 1'b0;
    rpos    = '0;
    s       = '0;
    ev_ext  = '0;
    rsp_d   = '0;
    slot_ext = '0;

    unique case (req_q.cmd)
      bbc_pkg::CMD_GET: begin
        if (found_q) begin
          s         = slot_q;
          rsp_d.hit = 1'b1;
          if (cnt_q[s] == '0) begin
            rm     = in_list_q;
            rpos   = pos_q;
            held_d = held_q + 1'b1;
          end
          if (cnt_q[s] == CountMax) rsp_d.status = bbc_pkg::ST_SAT;
          else cnt_d[s] = cnt_q[s] + 1'b1;
          slot_ext = 32'(s);
        end else if (len_q == '0) begin
          rsp_d.status = bbc_pkg::ST_NO_FREE;
        end else begin
          s      = lru_q[0];
          rm     = 1'b1;
          held_d = held_q + 1'b1;
          if (valid_q[s] && dirty_q[s]) begin
            rsp_d.write_back = 1'b1;
            ev_ext           = 32'(tag_q[s]);
          end
          dirty_d[s]      = 1'b0;
          tag_d[s]        = blk;
          valid_d[s]      = 1'b1;
          cnt_d[s]        = COUNT_BITS'(1);
          rsp_d.need_read = 1'b1;
          slot_ext        = 32'(s);
        end
      end
      bbc_pkg::CMD_RELEASE: begin
        slot_ext = idx_ext;
        if (!idx_ok || (cnt_q[idx] == '0)) begin
          rsp_d.status = bbc_pkg::ST_UNHELD;
        end else begin
          cnt_d[idx] = cnt_q[idx] - 1'b1;
          if (cnt_q[idx] == COUNT_BITS'(1)) begin
            app = (len_q < NumB);
            if (held_q != '0) held_d = held_q - 1'b1;
          end
        end
      end
      bbc_pkg::CMD_DIRTY: begin
        slot_ext = idx_ext;
        if (idx_ok) dirty_d[idx] = 1'b1;
      end
      bbc_pkg::CMD_NOP: begin
        slot_ext = '0;
      end
      default: begin
        slot_ext = '0;
      end
    endcase

    // Close the gap left by a removed entry.
    if (rm) begin
      for (int i = 0; i < NUM_BUFFERS - 1; i++) begin
        if ((IW'(i) >= rpos) && (HW'(i + 1) < len_q)) lru_d[i] = lru_q[i + 1];
      end
      len_d = len_q - 1'b1;
    end
    if (app) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        if (HW'(i) == len_q) lru_d[i] = idx;
      end
      len_d = len_q + 1'b1;
    end

    held_ext            = 32'(held_d);
    rsp_d.buffer_slot   = slot_ext[4:0];
    rsp_d.evicted_block = ev_ext[23:0];
    rsp_d.held_count    = held_ext[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_q[i] <= '0;
        cnt_q[i] <= '0;
        lru_q[i] <= IW'(i);
      end
      valid_q <= '0;
      dirty_q <= '0;
      len_q   <= NumB;
      held_q  <= '0;
    end else if (ctrl_i.update) begin
      tag_q   <= tag_d;
      cnt_q   <= cnt_d;
      lru_q   <= lru_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      len_q   <= len_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) req_q <= req_i;
    if (ctrl_i.lookup) begin
      found_q <= found_d;
      slot_q  <= slot_d;
    end
    if (ctrl_i.locate) begin
      in_list_q <= in_list_d;
      pos_q     <= pos_d;
    end
    if (ctrl_i.update) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

  // Every buffer is either on the free list or held.
  `BBC_ASSERT(a_pool_conserved, (32'(len_q) + 32'(held_q)) == 32'(NUM_BUFFERS))
  `BBC_ASSERT(a_len_bound, len_q <= NumB)
  `BBC_ASSERT(a_held_bound, held_q <= NumB)

endmodule

FILE: bench/tb.sv
// Self-checking bench for the block buffer cache tag manager.
// Drives get/release/mark-dirty requests and checks each result against a predictor.
// Depends on bbc_pkg and block_buffer_cache_lru.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBUF = 32;
  localparam int CMAX = 255;
  localparam int WATCHDOG = 2000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  bbc_pkg::req_t  req_i = '0;
  logic           busy_o, done_o;
  bbc_pkg::rsp_t  rsp_o;

  block_buffer_cache_lru i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .rsp_o(rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [23:0]   tags [NBUF];
  logic          valid [NBUF];
  int            refs [NBUF];
  logic          dirty [NBUF];
  int            free_list [$];
  int            held;
  bbc_pkg::rsp_t pending_rsp [$];
  int            errors = 0;
  int            idle_pct = 0;
  int            quiet = 0;

  function automatic bbc_pkg::rsp_t cache_step(bbc_pkg::req_t r);
    bbc_pkg::rsp_t o;
    int s;
    o = '0;
    s = -1;
    case (r.cmd)
      bbc_pkg::CMD_GET: begin
        for (int i = 0; i < NBUF; i++)
          if (s < 0 && valid[i] && tags[i] == r.block_number) s = i;
        if (s >= 0) begin
          o.hit = 1'b1;
          o.buffer_slot = s[4:0];
          if (refs[s] == 0) begin
            foreach (free_list[k]) if (free_list[k] == s) begin
              free_list.delete(k);
              break;
            end
            held++;
          end
          if (refs[s] >= CMAX) o.status = bbc_pkg::ST_SAT;
          else refs[s]++;
        end else if (free_list.size() == 0) begin
          o.status = bbc_pkg::ST_NO_FREE;
        end else begin
          s = free_list.pop_front();
          o.buffer_slot = s[4:0];
          held++;
          if (valid[s] && dirty[s]) begin
            o.write_back = 1'b1;
            o.evicted_block = tags[s];
          end
          dirty[s] = 1'b0;
          tags[s] = r.block_number;
          valid[s] = 1'b1;
          refs[s] = 1;
          o.need_read = 1'b1;
        end
      end
      bbc_pkg::CMD_RELEASE: begin
        o.buffer_slot = r.buffer_index;
        if (refs[r.buffer_index] == 0) begin
          o.status = bbc_pkg::ST_UNHELD;
        end else begin
          refs[r.buffer_index]--;
          if (refs[r.buffer_index] == 0) begin
            free_list.push_back(int'(r.buffer_index));
            if (held > 0) held--;
          end
        end
      end
      bbc_pkg::CMD_DIRTY: begin
        o.buffer_slot = r.buffer_index;
        dirty[r.buffer_index] = 1'b1;
      end
      default: ;
    endcase
    o.held_count = held[5:0];
    return o;
  endfunction

  // drive one request, with a random hold-off before it; start stays high
  // until the next request or the end of the stimulus drops it
  task automatic send(bbc_pkg::req_t r, bit typed, bbc_pkg::rsp_t want);
    bbc_pkg::rsp_t p;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    p = cache_step(r);
    if (typed && p != want) begin
      $display("%0t directed row disagrees: typed %h predicted %h", $time, want, p);
      errors++;
    end
    pending_rsp.push_back(p);
  endtask

  function automatic bbc_pkg::req_t mk(bbc_pkg::cmd_e c, logic [23:0] b, logic [4:0] x);
    bbc_pkg::req_t r;
    r.cmd = c;
    r.block_number = b;
    r.buffer_index = x;
    return r;
  endfunction

  function automatic bbc_pkg::rsp_t rs(int slot, bit h, bit rd, bit wb, int ev, int hc,
                                       bbc_pkg::status_e st);
    bbc_pkg::rsp_t o;
    o.buffer_slot = slot[4:0];
    o.hit = h;
    o.need_read = rd;
    o.write_back = wb;
    o.evicted_block = ev[23:0];
    o.held_count = hc[5:0];
    o.status = st;
    return o;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, rsp_o);
        errors++;
      end else begin
        bbc_pkg::rsp_t w;
        w = pending_rsp.pop_front();
        if (rsp_o.buffer_slot != w.buffer_slot || rsp_o.hit != w.hit ||
            rsp_o.need_read != w.need_read || rsp_o.write_back != w.write_back ||
            rsp_o.evicted_block != w.evicted_block ||
            rsp_o.held_count != w.held_count || rsp_o.status != w.status) begin
          $display("%0t result mismatch: expected %h actual %h", $time, w, rsp_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  typedef struct {
    bbc_pkg::req_t r;
    bit            typed;
    bbc_pkg::rsp_t want;
  } row_t;

  row_t rows [$];
  int   held_slots [$];
  int   base;

  initial begin
    for (int i = 0; i < NBUF; i++) begin
      tags[i] = '0; valid[i] = 0; refs[i] = 0; dirty[i] = 0;
      free_list.push_back(i);
    end
    held = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every command, unheld release, nop,
    // hit on unheld buffer
    rows.push_back('{mk(bbc_pkg::CMD_RELEASE, 0, 0), 1,
                     rs(0, 0, 0, 0, 0, 0, bbc_pkg::ST_UNHELD)});
    rows.push_back('{mk(bbc_pkg::CMD_NOP, 24'hFFFFFF, 31), 1,
                     rs(0, 0, 0, 0, 0, 0, bbc_pkg::ST_OK)});
    rows.push_back('{mk(bbc_pkg::CMD_GET, 0, 0), 1,
                     rs(0, 0, 1, 0, 0, 1, bbc_pkg::ST_OK)});
    rows.push_back('{mk(bbc_pkg::CMD_GET, 24'hFFFFFF, 31), 1,
                     rs(1, 0, 1, 0, 0, 2, bbc_pkg::ST_OK)});
    rows.push_back('{mk(bbc_pkg::CMD_GET, 0, 0), 1,
                     rs(0, 1, 0, 0, 0, 2, bbc_pkg::ST_OK)});
    rows.push_back('{mk(bbc_pkg::CMD_DIRTY, 0, 31), 1,
                     rs(31, 0, 0, 0, 0, 2, bbc_pkg::ST_OK)});
    rows.push_back('{mk(bbc_pkg::CMD_DIRTY, 0, 1), 1,
                     rs(1, 0, 0, 0, 0, 2, bbc_pkg::ST_OK)});
    rows.push_back('{mk(bbc_pkg::CMD_RELEASE, 0, 1), 1,
                     rs(1, 0, 0, 0, 0, 1, bbc_pkg::ST_OK)});
    rows.push_back('{mk(bbc_pkg::CMD_GET, 24'h5A5A5A, 0), 0, '0});
    rows.push_back('{mk(bbc_pkg::CMD_GET, 24'hFFFFFF, 0), 0, '0});
    rows.push_back('{mk(bbc_pkg::CMD_RELEASE, 0, 31), 1,
                     rs(31, 0, 0, 0, 0, 3, bbc_pkg::ST_UNHELD)});
    foreach (rows[i]) send(rows[i].r, rows[i].typed, rows[i].want);
    // fill the pool, then miss with nothing free
    for (int i = 0; i < 31; i++) send(mk(bbc_pkg::CMD_GET, 24'(24'h100 + i), 0), 0, '0);
    send(mk(bbc_pkg::CMD_GET, 24'hABCDEF, 0), 0, '0);
    // saturate one count on a buffer
    for (int i = 0; i < 256; i++) send(mk(bbc_pkg::CMD_GET, 24'h100, 0), 0, '0);
    for (int i = 0; i < 258; i++) send(mk(bbc_pkg::CMD_RELEASE, 0, 5'd2), 0, '0);
    for (int x = 0; x < NBUF; x++)
      while (refs[x] > 0) send(mk(bbc_pkg::CMD_RELEASE, 0, x[4:0]), 0, '0);

    // random: gets, mostly over a small block set, releases, mostly of held buffers, some mark-dirty and nop
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 34 : (ph == 1) ? 83 : 0;
      base = $urandom;
      for (int n = 0; n < 400; n++) begin
        int k;
        bbc_pkg::req_t r;
        k = $urandom_range(99);
        r = mk(bbc_pkg::CMD_NOP, 24'($urandom), 5'($urandom));
        if (k < 45) begin
          r.cmd = bbc_pkg::CMD_GET;
          if ($urandom_range(9) < 8) r.block_number = 24'(base + $urandom_range(47));
        end else if (k < 85) begin
          r.cmd = bbc_pkg::CMD_RELEASE;
          held_slots.delete();
          for (int x = 0; x < NBUF; x++) if (refs[x] > 0) held_slots.push_back(x);
          if (held_slots.size() > 0 && $urandom_range(9) < 9)
            r.buffer_index = 5'(held_slots[$urandom_range(held_slots.size() - 1)]);
        end else if (k < 97) begin
          r.cmd = bbc_pkg::CMD_DIRTY;
        end
        send(r, 0, '0);
      end
    end
    start_i <= 1'b0;

    while (pending_rsp.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
